>>> rtl/pls_pkg.sv
// Shared types and constants of the positional list store.
package pls_pkg;

   localparam int unsigned LEN_W = 11;
   localparam int unsigned VAL_W = 32;
   localparam logic [LEN_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_FIND   = 2'd2,
      REQ_GET    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_BAD_POS = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

>>> rtl/positional_list_store.sv
// Top level of the positional list store: an ordered list of 32-bit values in one RAM.
//
// A request is taken at a rising edge with start high and busy low. Its kind
// is on req_type, with req_position and req_value beside it. Every request
// gives one response, shown for a single cycle with rsp_strobe high; the
// receiver cannot stall, and busy falls in the same cycle as the strobe.
// Requests with a bad position and inserts into a full list answer at
// once from the idle state, the strobe being registered at the edge that
// takes them. Inserts and removes move the list, and a find scans it, one
// entry per cycle through the single read and single write port of the
// entry RAM. The user must write the capacity register through csr_we and
// csr_wdata only while the block is idle; the block itself does not
// enforce this.
// Reset empties the list and sets the capacity to 1024; the RAM itself is
// not cleared, since only entries below the length are ever read.
module positional_list_store
   import pls_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_type,
   input  logic [LEN_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [LEN_W-1:0]        rsp_found_position,
   output logic [LEN_W-1:0]        rsp_count,
   input  logic                    csr_we,
   input  logic [LEN_W-1:0]        csr_wdata
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned WIDE_W = (AW > LEN_W) ? AW : LEN_W;
   localparam int unsigned DEPTH_CAP = (DEPTH > 2047) ? 2047 : DEPTH;
   localparam logic [LEN_W-1:0] DEPTH_LIM = LEN_W'(DEPTH_CAP);

   state_type        state_ff, state_in;
   req_code_type     op_ff, op_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] cap_ff, cap_in;
   logic [LEN_W-1:0] ptr_ff, ptr_in;
   logic [LEN_W-1:0] stop_ff, stop_in;
   logic             more_ff, more_in;
   logic             pend_ff, pend_in;
   logic [LEN_W-1:0] rd_addr_ff, rd_addr_in;
   logic [VAL_W-1:0] val_ff, val_in;

   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic [LEN_W-1:0] rsp_found_position_ff, rsp_found_position_in;
   logic [LEN_W-1:0] rsp_count_ff, rsp_count_in;

   logic             mem_wen, mem_ren;
   logic [LEN_W-1:0] mem_widx, mem_ridx;
   logic [VAL_W-1:0] mem_wdata, mem_rdata;
   logic [WIDE_W-1:0] waddr_wide, raddr_wide;

   logic             accept, pos_zero, ins_bad, rng_bad, full;
   logic [LEN_W-1:0] pos_idx;

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign pos_zero = (req_position == '0);
   assign pos_idx = req_position - 11'd1;
   assign ins_bad = pos_zero || ({1'b0, req_position} > ({1'b0, len_ff} + 12'd1));
   assign rng_bad = pos_zero || (req_position > len_ff);
   assign full = (len_ff >= cap_ff) || (len_ff >= DEPTH_LIM);

   assign waddr_wide = WIDE_W'(mem_widx);
   assign raddr_wide = WIDE_W'(mem_ridx);

   pls_ram #(
      .WIDTH(VAL_W),
      .DEPTH(DEPTH)
   ) u_entries (
      .clock  (clock),
      .wr_en  (mem_wen),
      .wr_addr(waddr_wide[AW-1:0]),
      .wr_data(mem_wdata),
      .rd_en  (mem_ren),
      .rd_addr(raddr_wide[AW-1:0]),
      .rd_data(mem_rdata)
   );

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      len_in = len_ff;
      cap_in = csr_we ? csr_wdata : cap_ff;
      ptr_in = ptr_ff;
      stop_in = stop_ff;
      more_in = more_ff;
      pend_in = 1'b0;
      rd_addr_in = rd_addr_ff;
      val_in = val_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_found_position_in = rsp_found_position_ff;
      rsp_count_in = rsp_count_ff;
      mem_wen = 1'b0;
      mem_widx = '0;
      mem_wdata = mem_rdata;
      mem_ren = 1'b0;
      mem_ridx = ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req_code_type'(req_type);
               val_in = req_value;
               rsp_status_in = STAT_OK;
               rsp_read_value_in = '0;
               rsp_found_position_in = '0;
               rsp_count_in = len_ff;
               case (req_code_type'(req_type))
                  REQ_INSERT: begin
                     if (ins_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_BAD_POS;
                     end else if (full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_FULL;
                     end else begin
                        state_in = ST_SCAN;
                        ptr_in = len_ff - 11'd1;
                        stop_in = pos_idx;
                        more_in = (req_position <= len_ff);
                     end
                  end
                  REQ_REMOVE: begin
                     if (rng_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_BAD_POS;
                     end else begin
                        state_in = ST_SCAN;
                        ptr_in = req_position;
                        stop_in = len_ff - 11'd1;
                        more_in = (req_position < len_ff);
                     end
                  end
                  REQ_FIND: begin
                     state_in = ST_SCAN;
                     ptr_in = len_ff - 11'd1;
                     stop_in = '0;
                     more_in = (len_ff != '0);
                  end
                  default: begin
                     if (rng_bad) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_BAD_POS;
                     end else begin
                        state_in = ST_SCAN;
                        ptr_in = pos_idx;
                        stop_in = pos_idx;
                        more_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (more_ff) begin
               mem_ren = 1'b1;
               pend_in = 1'b1;
               rd_addr_in = ptr_ff;
               more_in = (ptr_ff != stop_ff);
               ptr_in = (op_ff == REQ_REMOVE) ? ptr_ff + 11'd1 : ptr_ff - 11'd1;
            end
            case (op_ff)
               REQ_INSERT: begin
                  if (pend_ff) begin
                     mem_wen = 1'b1;
                     mem_widx = rd_addr_ff + 11'd1;
                  end else if (!more_ff) begin
                     mem_wen = 1'b1;
                     mem_widx = stop_ff;
                     mem_wdata = val_ff;
                     len_in = len_ff + 11'd1;
                     rsp_count_in = len_ff + 11'd1;
                     rsp_strobe_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               REQ_REMOVE: begin
                  if (pend_ff) begin
                     mem_wen = 1'b1;
                     mem_widx = rd_addr_ff - 11'd1;
                  end else if (!more_ff) begin
                     len_in = len_ff - 11'd1;
                     rsp_count_in = len_ff - 11'd1;
                     rsp_strobe_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               REQ_FIND: begin
                  if (pend_ff && (mem_rdata == val_ff)) begin
                     rsp_found_position_in = rd_addr_ff + 11'd1;
                     rsp_strobe_in = 1'b1;
                     state_in = ST_IDLE;
                     more_in = 1'b0;
                     pend_in = 1'b0;
                  end else if (!pend_ff && !more_ff) begin
                     rsp_strobe_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  if (pend_ff) begin
                     rsp_read_value_in = mem_rdata;
                     rsp_strobe_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
            more_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff <= '0;
         cap_ff <= CAP_RESET;
         more_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         cap_ff <= cap_in;
         more_ff <= more_in;
         pend_ff <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      ptr_ff <= ptr_in;
      stop_ff <= stop_in;
      rd_addr_ff <= rd_addr_in;
      val_ff <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_found_position_ff <= rsp_found_position_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_found_position = rsp_found_position_ff;
   assign rsp_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("Response shown while the block is still busy.");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= DEPTH_LIM)
      else $error("List length exceeds the storage depth.");

   a_len_step: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |=> (len_ff == $past(len_ff)) || rsp_strobe)
      else $error("List length changed without a response.");

   a_no_access_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !mem_wen && !mem_ren)
      else $error("Entry memory accessed while idle.");
`endif

endmodule

>>> rtl/pls_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pls_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> sim/positional_list_store_tb.sv
// Self-checking testbench of the positional list store: directed table, then random requests.
module positional_list_store_tb
   import pls_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH = 1024;
   localparam int IDLE_LIMIT = 8192;
   localparam int RANDOM_ITEMS = 552;
   localparam int PHASE_ITEMS = 46;
   localparam int CALM_ITEMS = 60;
   localparam int DRAIN_CYCLES = 20;
   localparam int DIRECTED_ROWS = 29;
   localparam logic [LEN_W-1:0] CAP_PLAN [10] = '{
      11'd1, 11'd16, 11'd1024, 11'd0, 11'd3, 11'd2047, 11'd64, 11'd1024, 11'd2, 11'd700
   };

   typedef enum logic {
      ROW_REQUEST  = 1'b0,
      ROW_CAPACITY = 1'b1
   } row_kind_type;

   typedef struct {
      status_type              status;
      logic signed [VAL_W-1:0] read_value;
      logic [LEN_W-1:0]        found_position;
      logic [LEN_W-1:0]        count;
   } list_result_type;

   typedef struct {
      row_kind_type            what;
      req_code_type            kind;
      logic [LEN_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
      logic [LEN_W-1:0]        capacity;
      logic                    typed;
      list_result_type         want;
   } request_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_type = REQ_INSERT;
   logic [LEN_W-1:0]        req_position = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_strobe;
   logic [1:0]              rsp_status;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic [LEN_W-1:0]        rsp_found_position;
   logic [LEN_W-1:0]        rsp_count;
   logic                    csr_we = 1'b0;
   logic [LEN_W-1:0]        csr_wdata = '0;

   logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
   int                      list_len;
   int                      list_cap;
   list_result_type         awaited_responses [$];
   list_result_type         head_response;
   int                      error_count = 0;
   int                      quiet_cycles = 0;

   request_row_type directed_requests [DIRECTED_ROWS] = '{
      '{ROW_REQUEST, REQ_GET, 11'd1, 32'sd0, 11'd0, 1'b1, '{STAT_BAD_POS, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_REMOVE, 11'd0, 32'sd0, 11'd0, 1'b1,
         '{STAT_BAD_POS, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_FIND, 11'd0, 32'sd5, 11'd0, 1'b1, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_INSERT, 11'd2, 32'sd9, 11'd0, 1'b1,
         '{STAT_BAD_POS, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_INSERT, 11'd0, 32'sd9, 11'd0, 1'b1,
         '{STAT_BAD_POS, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_INSERT, 11'd1, 32'sh7FFFFFFF, 11'd0, 1'b1,
         '{STAT_OK, 32'sd0, 11'd0, 11'd1}},
      '{ROW_REQUEST, REQ_INSERT, 11'd1, 32'sh80000000, 11'd0, 1'b1,
         '{STAT_OK, 32'sd0, 11'd0, 11'd2}},
      '{ROW_REQUEST, REQ_GET, 11'd1, 32'sd0, 11'd0, 1'b1,
         '{STAT_OK, 32'sh80000000, 11'd0, 11'd2}},
      '{ROW_REQUEST, REQ_INSERT, 11'd3, 32'sd0, 11'd0, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_INSERT, 11'd2, -32'sd1, 11'd0, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_INSERT, 11'd5, 32'sh7FFFFFFF, 11'd0, 1'b0,
         '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_FIND, 11'd2047, 32'sh7FFFFFFF, 11'd0, 1'b0,
         '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_FIND, 11'd1, 32'sh80000000, 11'd0, 1'b0,
         '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_GET, 11'd5, 32'sd0, 11'd0, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_GET, 11'd1025, -32'sd1, 11'd0, 1'b1,
         '{STAT_BAD_POS, 32'sd0, 11'd0, 11'd5}},
      '{ROW_REQUEST, REQ_REMOVE, 11'd1024, 32'sd0, 11'd0, 1'b1,
         '{STAT_BAD_POS, 32'sd0, 11'd0, 11'd5}},
      '{ROW_REQUEST, REQ_INSERT, 11'd7, 32'sd1, 11'd0, 1'b1,
         '{STAT_BAD_POS, 32'sd0, 11'd0, 11'd5}},
      '{ROW_REQUEST, REQ_REMOVE, 11'd3, 32'sd0, 11'd0, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_CAPACITY, REQ_GET, 11'd0, 32'sd0, 11'd2, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_INSERT, 11'd9, 32'sd3, 11'd0, 1'b1,
         '{STAT_BAD_POS, 32'sd0, 11'd0, 11'd4}},
      '{ROW_REQUEST, REQ_INSERT, 11'd1, 32'sd3, 11'd0, 1'b1, '{STAT_FULL, 32'sd0, 11'd0, 11'd4}},
      '{ROW_REQUEST, REQ_REMOVE, 11'd1, 32'sd0, 11'd0, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_REMOVE, 11'd1, 32'sd0, 11'd0, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_REMOVE, 11'd2, 32'sd0, 11'd0, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_INSERT, 11'd2, 32'sd11, 11'd0, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_CAPACITY, REQ_GET, 11'd0, 32'sd0, 11'd0, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_INSERT, 11'd1, 32'sd4, 11'd0, 1'b1, '{STAT_FULL, 32'sd0, 11'd0, 11'd2}},
      '{ROW_CAPACITY, REQ_GET, 11'd0, 32'sd0, 11'd2047, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}},
      '{ROW_REQUEST, REQ_GET, 11'd2, 32'sd0, 11'd0, 1'b0, '{STAT_OK, 32'sd0, 11'd0, 11'd0}}
   };

   positional_list_store #(
      .DEPTH(LIST_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_read_value(rsp_read_value),
      .rsp_found_position(rsp_found_position),
      .rsp_count(rsp_count),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic list_result_type perform_list_request(input req_code_type kind,
                                                            input logic [LEN_W-1:0] pos,
                                                            input logic signed [VAL_W-1:0] val);
      list_result_type r;
      int p;
      int limit;
      p = int'(pos);
      limit = (list_cap < LIST_DEPTH) ? list_cap : LIST_DEPTH;
      r.status = STAT_OK;
      r.read_value = '0;
      r.found_position = '0;
      case (kind)
         REQ_INSERT: begin
            if (p < 1 || p > list_len + 1) begin
               r.status = STAT_BAD_POS;
            end else if (list_len >= limit) begin
               r.status = STAT_FULL;
            end else begin
               for (int k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
               list_mem[p-1] = val;
               list_len++;
            end
         end
         REQ_REMOVE: begin
            if (p < 1 || p > list_len) begin
               r.status = STAT_BAD_POS;
            end else begin
               for (int k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
               list_len--;
            end
         end
         REQ_FIND: begin
            for (int k = list_len; k >= 1; k--) begin
               if (list_mem[k-1] == val) begin
                  r.found_position = LEN_W'(k);
                  break;
               end
            end
         end
         default: begin
            if (p < 1 || p > list_len) r.status = STAT_BAD_POS;
            else r.read_value = list_mem[p-1];
         end
      endcase
      r.count = LEN_W'(list_len);
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] draw_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6, 7: return $signed(VAL_W'($urandom_range(0, 7))) - 4;
         8: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] draw_position(input req_code_type kind);
      int top;
      top = (kind == REQ_INSERT) ? list_len + 1 : list_len;
      if (kind != REQ_FIND && top >= 1 && $urandom_range(0, 9) != 0)
         return LEN_W'($urandom_range(1, top));
      case ($urandom_range(0, 3))
         0: return '0;
         1: return LEN_W'(top + 1);
         2: return LEN_W'(1024 + $urandom_range(0, 1));
         default: return LEN_W'($urandom_range(0, 1025));
      endcase
   endfunction

   task automatic issue_request(input req_code_type kind, input logic [LEN_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val, input logic typed,
                                input list_result_type want);
      list_result_type predicted;
      start <= 1'b1;
      req_type <= kind;
      req_position <= pos;
      req_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = perform_list_request(kind, pos, val);
      awaited_responses.push_back(typed ? want : predicted);
   endtask

   task automatic write_capacity(input logic [LEN_W-1:0] cap);
      start <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
      list_cap = int'(cap);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("positional_list_store_tb failed");
            $finish;
         end else if (rsp_strobe) begin
            if (awaited_responses.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               head_response = awaited_responses.pop_front();
               if (rsp_status !== head_response.status) begin
                  $error("status: expected %0d, actual %0d", head_response.status, rsp_status);
                  error_count++;
               end
               if (rsp_read_value !== head_response.read_value) begin
                  $error("read_value: expected %0d, actual %0d",
                         head_response.read_value, rsp_read_value);
                  error_count++;
               end
               if (rsp_found_position !== head_response.found_position) begin
                  $error("found_position: expected %0d, actual %0d",
                         head_response.found_position, rsp_found_position);
                  error_count++;
               end
               if (rsp_count !== head_response.count) begin
                  $error("count: expected %0d, actual %0d", head_response.count, rsp_count);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      req_code_type            kind;
      logic [LEN_W-1:0]        pos;
      logic signed [VAL_W-1:0] val;
      list_result_type         unused_result;
      int                      roll;
      int                      phase;
      bit                      bursty;
      unused_result = '{STAT_OK, 32'sd0, 11'd0, 11'd0};
      bursty = 1'b0;
      foreach (list_mem[i]) list_mem[i] = '0;
      list_len = 0;
      list_cap = int'(CAP_RESET);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_requests[i]) begin
         if (directed_requests[i].what == ROW_CAPACITY) begin
            write_capacity(directed_requests[i].capacity);
         end else begin
            issue_request(directed_requests[i].kind, directed_requests[i].position,
                          directed_requests[i].value, directed_requests[i].typed,
                          directed_requests[i].want);
         end
      end

      for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
         if (idx % PHASE_ITEMS == 0) begin
            phase = idx / PHASE_ITEMS;
            write_capacity(phase < $size(CAP_PLAN) ? CAP_PLAN[phase] :
                           LEN_W'($urandom_range(1, 1024)));
         end
         if (idx % 16 == 0) bursty = ($urandom_range(0, 2) != 0);
         if (idx < RANDOM_ITEMS - CALM_ITEMS && bursty && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         roll = $urandom_range(0, 99);
         if (roll < ((list_len > 150) ? 20 : 40)) kind = REQ_INSERT;
         else if (roll < 65) kind = REQ_REMOVE;
         else if (roll < 80) kind = REQ_FIND;
         else kind = REQ_GET;
         pos = draw_position(kind);
         if (kind == REQ_FIND && list_len > 0 && $urandom_range(0, 9) < 6)
            val = list_mem[$urandom_range(0, list_len - 1)];
         else
            val = draw_value();
         issue_request(kind, pos, val, 1'b0, unused_result);
      end

      start <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("positional_list_store_tb passed");
      end else begin
         $display("positional_list_store_tb failed");
      end
      $finish;
   end

endmodule
